>>> hdl/lrs_pkg.sv
// Shared types and constants for the LRU recency stack.
// Used by lrs_cfg, lrs_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
package lrs_pkg;

    localparam int CAP_W       = 5;
    localparam int KEY_FIELD_W = 32;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 72;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Members run from the highest bit down, so hit lands in bit 0.
    typedef struct packed {
        logic [CNT_W-1:0]       held_count;
        logic [KEY_FIELD_W-1:0] entry_key;
        logic                   entry_valid;
        logic [KEY_FIELD_W-1:0] evicted_key;
        logic                   evicted;
        logic                   hit;
    } result_t;

endpackage

>>> hdl/lrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; holds the recency keys.
`timescale 1ns / 1ps
module lrs_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lrs_cfg.sv
// APB-style register port holding the capacity register.
// Depends on lrs_pkg.
`timescale 1ns / 1ps
module lrs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lrs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [lrs_pkg::CAP_W-1:0]      capacity
);
    import lrs_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             sel_capacity;

    assign sel_capacity = (paddr[2] == REG_CAPACITY);

    always_comb begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && sel_capacity) begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata   = sel_capacity ? APB_DATA_W'(capacity_reg) : '0;
    assign pready   = 1'b1;
    assign capacity = capacity_reg;

endmodule

>>> hdl/lrs_ctrl.sv
// Sequencer that walks the recency RAM one entry per cycle with a single
// key comparator, shifting entries as it goes. Depends on lrs_pkg.
`timescale 1ns / 1ps
module lrs_ctrl #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    parameter int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lrs_pkg::CAP_W-1:0]       capacity,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_op,
    input  logic [lrs_pkg::KEY_FIELD_W-1:0] in_key,
    input  logic [lrs_pkg::POS_W-1:0]       in_pos,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lrs_pkg::result_t                out_result,
    output logic                            mem_we,
    output logic [ADDR_W-1:0]               mem_waddr,
    output logic [KEY_WIDTH-1:0]            mem_wdata,
    output logic [ADDR_W-1:0]               mem_raddr,
    input  logic [KEY_WIDTH-1:0]            mem_rdata
);
    import lrs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] carry_reg, carry_next;
    result_t              res_reg, res_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        cap_eff;
    logic                 full;
    logic                 last;
    logic                 match;

    always_comb begin
        if (32'(capacity) > DEPTH) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(capacity);
        end
    end

    assign full  = (count_reg >= cap_eff);
    assign last  = (CW'(idx_reg) == (count_reg - CW'(1)));
    assign match = (mem_rdata == key_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        carry_next     = carry_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = carry_reg;
        mem_raddr      = '0;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                mem_raddr = ADDR_W'(in_pos);
                if (in_valid) begin
                    res_next   = '0;
                    key_next   = KEY_WIDTH'(in_key);
                    carry_next = KEY_WIDTH'(in_key);
                    if (in_op == OP_READ) begin
                        res_next.entry_valid = (32'(in_pos) < 32'(count_reg));
                        state_next = S_RD;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end
            S_PUT: begin
                if (count_reg == '0) begin
                    if (full) begin
                        res_next.evicted     = 1'b1;
                        res_next.evicted_key = KEY_FIELD_W'(key_reg);
                    end else begin
                        mem_we     = 1'b1;
                        count_next = CW'(1);
                    end
                    state_next = S_DONE;
                end else begin
                    idx_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                mem_raddr  = idx_reg + ADDR_W'(1);
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                carry_next = mem_rdata;
                if (match) begin
                    res_next.hit = 1'b1;
                    state_next   = S_DONE;
                end else if (last) begin
                    if (full) begin
                        res_next.evicted     = 1'b1;
                        res_next.evicted_key = KEY_FIELD_W'(mem_rdata);
                        state_next           = S_DONE;
                    end else begin
                        state_next = S_APPEND;
                    end
                end else begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_APPEND: begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(count_reg);
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_RD: begin
                if (res_reg.entry_valid) begin
                    res_next.entry_key = KEY_FIELD_W'(mem_rdata);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_next            = res_reg;
                    out_next.held_count = CNT_W'(count_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        key_reg   <= key_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

>>> hdl/lru_recency_stack_top.sv
// Top level of the LRU recency stack: register port, sequencer and key RAM.
// Depends on lrs_pkg, lrs_cfg, lrs_ctrl and lrs_ram.
//
//   Channel  Dir  Handshake            Contents
//   s_       in   s_tvalid/s_tready    tuser: operation; tdata: key, position
//   m_       out  m_tvalid/m_tready    tdata: hit, evicted, keys, held_count
//   APB      in   psel/penable/pwrite  capacity register at byte address 0
//
// A read passes through S_RD to S_DONE, where the result register is loaded.
// A put into an empty store goes from S_PUT to S_DONE; otherwise it walks the
// keys from position 0 in S_WALK over the key RAM's single read port, stopping
// on a hit or at the last key, where it drops the least recent key or appends.
// Reset is synchronous and leaves the store empty; the RAM is not cleared.
// A held result does not block acceptance; the next result waits for it.
`timescale 1ns / 1ps
module lru_recency_stack_top #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lrs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata fields from bit 0: key [31:0], position [35:32], zero padding.
    input  logic [lrs_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser fields from bit 0: operation.
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata fields from bit 0: hit, evicted, evicted_key, entry_valid,
    // entry_key, held_count.
    output logic [lrs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lrs_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CAP_W-1:0]     capacity;
    result_t              result;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [KEY_WIDTH-1:0] mem_rdata;

    lrs_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    lrs_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity   (capacity),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_key     (s_tdata[KEY_FIELD_W-1:0]),
        .in_pos     (s_tdata[KEY_FIELD_W+POS_W-1:KEY_FIELD_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    lrs_ram #(
        .WIDTH  (KEY_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = result;

endmodule
